// ===== rtl/core/ntc_pkg.sv =====
// Package: constants and log table for the thermistor to Celsius converter.
`default_nettype none

package ntc_pkg;

    localparam int DEVICES             = 8;
    localparam int CHANNELS_PER_DEVICE = 16;

    localparam int CODE_W  = 16;
    localparam int BETA_W  = 14;
    localparam int TEMP_W  = 11;
    localparam int SLOT_W  = 7;
    localparam int DEV_W   = 3;
    localparam int CHAN_W  = 4;
    localparam int CFG_W   = 16;
    localparam int LN_W    = 20;
    localparam int QUO_W   = 27;
    localparam int DEN_W   = 31;

    localparam logic [0:0]  CFG_BETA = 1'd0;
    localparam logic [0:0]  CFG_FS   = 1'd1;

    localparam logic [BETA_W-1:0] BETA_RST = 14'd3435;
    localparam logic [CODE_W-1:0] FS_RST   = 16'd30000;

    localparam logic [15:0] LN2_Q16    = 16'd45426;
    localparam logic [25:0] T0_Q16     = 26'd19539558;
    localparam logic [28:0] KELVIN_Q16 = 29'd17901158;
    localparam logic signed [TEMP_W-1:0] TEMP_ERR = 11'sd999;

    function automatic logic [15:0] f_ln_tab(input logic [4:0] k);
        logic [15:0] v;
        case (k)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3973;
            5'd2:    v = 16'd7719;
            5'd3:    v = 16'd11262;
            5'd4:    v = 16'd14624;
            5'd5:    v = 16'd17821;
            5'd6:    v = 16'd20870;
            5'd7:    v = 16'd23783;
            5'd8:    v = 16'd26573;
            5'd9:    v = 16'd29248;
            5'd10:   v = 16'd31818;
            5'd11:   v = 16'd34292;
            5'd12:   v = 16'd36675;
            5'd13:   v = 16'd38975;
            5'd14:   v = 16'd41196;
            5'd15:   v = 16'd43347;
            5'd16:   v = 16'd45426;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ntc_thermistor_to_celsius.sv =====
// Top level: pipelined NTC thermistor code to degrees Celsius converter.
//
// Usage:
//   Pulse start with adc_code, device and channel; busy stays low, so an item
//   can be issued on every clock cycle. Each item yields one result on
//   o_temp_c, o_slot and o_error, shown for one cycle with o_done high.
//   Throughput is one item per cycle. The pipeline holds the capture
//   stage, the log normalize, log interpolate, multiply and denominator
//   stages, the 27-stage restoring divider that forms the kelvin value,
//   one quotient bit per stage, and the output register.
//   Configuration: i_cfg_we with i_cfg_idx 0 (beta) or 1 (full scale)
//   writes i_cfg_wdata at the clock edge; write only while no item is in
//   flight.
//   Reset (i_rst_n low, synchronous) clears all valid bits and reloads
//   beta 3435 and full scale 30000. The receiver cannot stall; results
//   are taken in the cycle they appear.
`default_nettype none

module ntc_thermistor_to_celsius
    import ntc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [CODE_W-1:0]        i_adc_code,
    input  wire logic [DEV_W-1:0]         i_device,
    input  wire logic [CHAN_W-1:0]        i_channel,
    input  wire logic                     i_cfg_we,
    input  wire logic [0:0]               i_cfg_idx,
    input  wire logic [CFG_W-1:0]         i_cfg_wdata,
    output logic                          o_done,
    output logic signed [TEMP_W-1:0]      o_temp_c,
    output logic [SLOT_W-1:0]             o_slot,
    output logic                          o_error
);

    logic [BETA_W-1:0] r_beta;
    logic [CODE_W-1:0] r_fs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta <= BETA_RST;
            r_fs   <= FS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BETA: r_beta <= i_cfg_wdata[BETA_W-1:0];
                CFG_FS:   r_fs   <= i_cfg_wdata;
                default:  r_fs   <= r_fs;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage A: capture
    logic              r_a_vld, r_a_err;
    logic [CODE_W-1:0] r_a_code, r_a_diff;
    logic [SLOT_W-1:0] r_a_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start;
        end
        r_a_code <= i_adc_code;
        r_a_diff <= r_fs - i_adc_code;
        r_a_err  <= (i_adc_code == '0) || (i_adc_code >= r_fs);
        r_a_slot <= SLOT_W'(32'(i_device) * CHANNELS_PER_DEVICE + 32'(i_channel));
    end

    // stage B: normalize both operands
    logic [3:0]  n_b_p   [2];
    logic [4:0]  n_b_i   [2];
    logic [10:0] n_b_r   [2];
    logic [CODE_W-1:0] w_x [2];
    logic [CODE_W-1:0] w_m [2];
    logic [3:0]  r_b_p   [2];
    logic [15:0] r_b_lo  [2];
    logic [11:0] r_b_dlt [2];
    logic [10:0] r_b_r   [2];
    logic        r_b_vld, r_b_err;
    logic [SLOT_W-1:0] r_b_slot;

    assign w_x[0] = r_a_code;
    assign w_x[1] = r_a_diff;

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            n_b_p[j] = 4'd0;
            for (int k = 0; k < CODE_W; k++) begin
                if (w_x[j][k]) begin
                    n_b_p[j] = 4'(k);
                end
            end
            w_m[j]   = w_x[j] << (4'd15 - n_b_p[j]);
            n_b_i[j] = {1'b0, w_m[j][14:11]};
            n_b_r[j] = w_m[j][10:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        for (int j = 0; j < 2; j++) begin
            r_b_p[j]   <= n_b_p[j];
            r_b_lo[j]  <= f_ln_tab(n_b_i[j]);
            r_b_dlt[j] <= 12'(f_ln_tab(n_b_i[j] + 5'd1) - f_ln_tab(n_b_i[j]));
            r_b_r[j]   <= n_b_r[j];
        end
        r_b_err  <= r_a_err;
        r_b_slot <= r_a_slot;
    end

    // stage C: interpolate logs
    logic [LN_W-1:0] r_c_ln [2];
    logic [23:0]     w_c_ip [2];
    logic            r_c_vld, r_c_err;
    logic [SLOT_W-1:0] r_c_slot;

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            w_c_ip[j] = 24'(r_b_dlt[j]) * 24'(r_b_r[j]) + 24'd1024;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        for (int j = 0; j < 2; j++) begin
            r_c_ln[j] <= LN_W'(r_b_p[j]) * LN_W'(LN2_Q16) + LN_W'(r_b_lo[j])
                       + LN_W'(w_c_ip[j] >> 11);
        end
        r_c_err  <= r_b_err;
        r_c_slot <= r_b_slot;
    end

    // stage D: multiply
    logic signed [LN_W:0]  w_d_d;
    logic signed [45:0]    r_d_prod;
    logic [39:0]           r_d_bt;
    logic                  r_d_vld, r_d_err;
    logic [SLOT_W-1:0]     r_d_slot;

    assign w_d_d = $signed({1'b0, r_c_ln[0]}) - $signed({1'b0, r_c_ln[1]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_prod <= 46'(w_d_d) * $signed({1'b0, T0_Q16});
        r_d_bt   <= 40'(r_beta) * 40'(T0_Q16);
        r_d_err  <= r_c_err;
        r_d_slot <= r_c_slot;
    end

    // stage E: denominator and divider setup
    logic signed [29:0] w_e_sh;
    logic signed [31:0] w_e_den;
    logic [28:0]        w_e_hi;

    assign w_e_sh  = r_d_prod[45] ? 30'((r_d_prod + 46'sd65535) >>> 16)
                                  : 30'(r_d_prod >>> 16);
    assign w_e_den = $signed({2'b00, r_beta, 16'd0}) + 32'(w_e_sh);
    assign w_e_hi  = r_d_bt[39:11];

    logic              r_v_vld   [QUO_W+1];
    logic              r_v_err   [QUO_W+1];
    logic              r_v_force [QUO_W+1];
    logic [SLOT_W-1:0] r_v_slot  [QUO_W+1];
    logic [DEN_W-1:0]  r_v_den   [QUO_W+1];
    logic [DEN_W-1:0]  r_v_rem   [QUO_W+1];
    logic [QUO_W-1:0]  r_v_lo    [QUO_W+1];
    logic [QUO_W-1:0]  r_v_q     [QUO_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_vld[0] <= 1'b0;
        end else begin
            r_v_vld[0] <= r_d_vld;
        end
        r_v_err[0]   <= r_d_err;
        r_v_force[0] <= r_d_err || (w_e_den <= 32'sd0)
                     || ({3'b000, w_e_hi} >= w_e_den[DEN_W:0]);
        r_v_slot[0]  <= r_d_slot;
        r_v_den[0]   <= w_e_den[DEN_W-1:0];
        r_v_rem[0]   <= DEN_W'(w_e_hi);
        r_v_lo[0]    <= {r_d_bt[10:0], 16'd0};
        r_v_q[0]     <= '0;
    end

    // divider: one quotient bit per stage
    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        logic [DEN_W:0] w_trial;
        logic           w_ge;

        assign w_trial = {r_v_rem[g], r_v_lo[g][QUO_W-1]};
        assign w_ge    = w_trial >= {1'b0, r_v_den[g]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v_vld[g+1] <= 1'b0;
            end else begin
                r_v_vld[g+1] <= r_v_vld[g];
            end
            r_v_err[g+1]   <= r_v_err[g];
            r_v_force[g+1] <= r_v_force[g];
            r_v_slot[g+1]  <= r_v_slot[g];
            r_v_den[g+1]   <= r_v_den[g];
            r_v_rem[g+1]   <= w_ge ? DEN_W'(w_trial - {1'b0, r_v_den[g]})
                                   : DEN_W'(w_trial);
            r_v_lo[g+1]    <= r_v_lo[g] << 1;
            r_v_q[g+1]     <= {r_v_q[g][QUO_W-2:0], w_ge};
        end
    end

    // output stage: to Celsius, truncate, saturate
    logic signed [28:0] w_o_x;
    logic signed [12:0] w_o_t;

    assign w_o_x = $signed({2'b00, r_v_q[QUO_W]}) - $signed(KELVIN_Q16);
    assign w_o_t = w_o_x[28] ? -13'(((-w_o_x) >>> 16))
                             : 13'(w_o_x >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_v_vld[QUO_W];
        end
        o_slot  <= r_v_slot[QUO_W];
        o_error <= r_v_err[QUO_W];
        if (r_v_force[QUO_W] || (w_o_t > 13'sd999)) begin
            o_temp_c <= TEMP_ERR;
        end else begin
            o_temp_c <= TEMP_W'(w_o_t);
        end
    end

`ifndef ASSERT_OFF
    a_err_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_error |-> o_temp_c == TEMP_ERR)
        else $error("error item without error temperature");
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_temp_c >= -11'sd273) && (o_temp_c <= TEMP_ERR))
        else $error("temperature out of range");
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe after reset");
    a_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_vld |=> r_v_vld[0])
        else $error("valid lost between stages");
`endif

endmodule

`default_nettype wire
